>>> rtl/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg: shared types and codes for the sorted key table
// Command codes and the control word that the sequencer sends to every cell.
// ----------------------------------------------------------------------------
package skt_pkg;

    localparam logic [2:0] CMD_OPEN     = 3'd0;
    localparam logic [2:0] CMD_DELETE   = 3'd1;
    localparam logic [2:0] CMD_SET_MARK = 3'd2;
    localparam logic [2:0] CMD_QUERY    = 3'd3;
    localparam logic [2:0] CMD_CLEAR    = 3'd4;

    localparam int OUT_POS_BITS = 9;

    // Control broadcast to the cell row
    typedef struct packed {
        logic capture;   // register compare flags against the broadcast key
        logic do_ins;    // shift up and insert at the first cell not below the key
        logic do_del;    // shift down over the matching cell
        logic do_set;    // write the mark of the matching cell
        logic do_clr;    // empty every cell
        logic mval;      // mark bit for a set
    } skt_ctl_t;

endpackage

>>> rtl/skt_cell.sv
// ----------------------------------------------------------------------------
// skt_cell: one entry of the sorted key table
// Holds a key, its mark and a valid bit, compares against the broadcast key
// and takes its neighbor's entry when the row shifts.
// ----------------------------------------------------------------------------
module skt_cell
    import skt_pkg::*;
#(
    parameter int KEY_BITS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  skt_ctl_t            ctl,
    input  logic [KEY_BITS-1:0] key_in,
    input  logic [KEY_BITS-1:0] prev_key,
    input  logic                prev_mark,
    input  logic                prev_valid,
    input  logic                prev_lt,
    input  logic [KEY_BITS-1:0] next_key,
    input  logic                next_mark,
    input  logic                next_valid,
    output logic [KEY_BITS-1:0] cell_key,
    output logic                cell_mark,
    output logic                cell_valid,
    output logic                lt_flag,
    output logic                eq_flag
);

    logic [KEY_BITS-1:0] key_reg, key_next;
    logic                mark_reg, mark_next;
    logic                valid_reg, valid_next;
    logic                lt_reg, eq_reg;
    logic                lt_now, eq_now;

    // Compare the held key against the broadcast key (signed)
    assign lt_now = valid_reg && ($signed(key_reg) < $signed(key_in));
    assign eq_now = valid_reg && (key_reg == key_in);

    // Register the compare flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg <= 1'b0;
            eq_reg <= 1'b0;
        end
        else if (ctl.capture)
        begin
            lt_reg <= lt_now;
            eq_reg <= eq_now;
        end
    end

    // Select the next entry: hold, take a neighbor, insert, mark or clear
    always_comb
    begin
        key_next   = key_reg;
        mark_next  = mark_reg;
        valid_next = valid_reg;
        if (ctl.do_clr)
        begin
            mark_next  = 1'b0;
            valid_next = 1'b0;
        end
        else if (ctl.do_ins && !lt_reg)
        begin
            if (prev_lt)
            begin
                key_next   = key_in;
                mark_next  = 1'b0;
                valid_next = 1'b1;
            end
            else
            begin
                key_next   = prev_key;
                mark_next  = prev_mark;
                valid_next = prev_valid;
            end
        end
        else if (ctl.do_del && !lt_reg)
        begin
            key_next   = next_key;
            mark_next  = next_mark;
            valid_next = next_valid;
        end
        else if (ctl.do_set && eq_reg)
        begin
            mark_next = ctl.mval;
        end
    end

    // Hold the entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            mark_reg  <= mark_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign cell_key   = key_reg;
    assign cell_mark  = mark_reg;
    assign cell_valid = valid_reg;
    assign lt_flag    = lt_reg;
    assign eq_flag    = eq_reg;

endmodule

>>> rtl/skt_encode.sv
// ----------------------------------------------------------------------------
// skt_encode: lookup summary of the cell row
// Turns the row's less-than thermometer into a position and folds the match
// flags into found and the matching entry's mark.
// ----------------------------------------------------------------------------
module skt_encode
#(
    parameter int TABLE_DEPTH = 256,
    localparam int PW = $clog2(TABLE_DEPTH + 1)
)
(
    input  logic [TABLE_DEPTH-1:0] lt_vec,
    input  logic [TABLE_DEPTH-1:0] eq_vec,
    input  logic [TABLE_DEPTH-1:0] mark_vec,
    output logic [PW-1:0]          pos,
    output logic                   hit,
    output logic                   hit_mark
);

    logic [TABLE_DEPTH+1:0] therm;
    logic [TABLE_DEPTH:0]   edge_hot;

    // Pad the thermometer: virtual one before the row, zero after it
    assign therm = {1'b0, lt_vec, 1'b1};

    // Mark the single one-to-zero step and encode its index
    always_comb
    begin
        pos = '0;
        for (int i = 0; i <= TABLE_DEPTH; i++)
        begin
            edge_hot[i] = therm[i] & ~therm[i+1];
            if (edge_hot[i])
            begin
                pos = pos | PW'(i);
            end
        end
    end

    assign hit      = |eq_vec;
    assign hit_mark = |(eq_vec & mark_vec);

endmodule

>>> rtl/sorted_key_table_with_marks.sv
// ----------------------------------------------------------------------------
// sorted_key_table_with_marks: sorted signed key table with mark bits
// A row of cells keeps the keys in ascending order; each command looks up
// its key, then opens, deletes, marks, queries or clears in one shift.
// ----------------------------------------------------------------------------
//  channel | signals                                   | dir | handshake
//  --------+-------------------------------------------+-----+----------------
//  input   | cmd, key, mark_value                      | in  | in_valid/in_stall
//  output  | found, position, mark, full_error,        | out | out_valid/
//          | entry_count                               |     | out_stall
//
//  A command runs in two phases: every cell registers its compare against
//  the key, then the position is encoded and the row shifts. The next command
//  is taken in the cycle its predecessor shifts, so a new word is accepted
//  while the last one shifts; the compare-then-shift through the cell row
//  limits the rate. A stalled result holds the row in its shift cycle.
//  Reset empties the table at once; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_key_table_with_marks
    import skt_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int KEY_BITS    = 32
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [2:0]                 cmd,
    input  logic signed [KEY_BITS-1:0] key,
    input  logic                       mark_value,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       found,
    output logic [OUT_POS_BITS-1:0]    position,
    output logic                       mark,
    output logic                       full_error,
    output logic [OUT_POS_BITS-1:0]    entry_count
);

    localparam int PW = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_CMP  = 2'd1;
    localparam logic [1:0] PH_UPD  = 2'd2;

    logic [1:0]          phase_reg, phase_next;
    logic [2:0]          cmd_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic                mval_reg;
    logic [PW-1:0]       count_reg, count_next;

    logic                out_valid_reg;
    logic                found_reg, found_next;
    logic [PW-1:0]       pos_reg;
    logic                mark_reg, mark_next;
    logic                full_reg, full_next;

    logic                in_take;
    logic                upd_go;
    logic                table_full;
    skt_ctl_t            ctl;

    logic [KEY_BITS-1:0]    cell_key   [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] cell_mark;
    logic [TABLE_DEPTH-1:0] cell_valid;
    logic [TABLE_DEPTH-1:0] lt_vec;
    logic [TABLE_DEPTH-1:0] eq_vec;

    logic [PW-1:0]       enc_pos;
    logic                enc_hit;
    logic                enc_mark;

    logic [PW+OUT_POS_BITS-1:0] pos_wide;
    logic [PW+OUT_POS_BITS-1:0] count_wide;

    // Handshake
    assign upd_go   = (phase_reg == PH_UPD) && (!out_valid_reg || !out_stall);
    assign in_stall = !((phase_reg == PH_IDLE) || upd_go);
    assign in_take  = in_valid && !in_stall;

    // Advance the command phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (in_take)
                begin
                    phase_next = PH_CMP;
                end
            end
            PH_CMP:
            begin
                phase_next = PH_UPD;
            end
            PH_UPD:
            begin
                if (upd_go)
                begin
                    phase_next = in_take ? PH_CMP : PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    // Hold the accepted command word
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg  <= cmd;
            key_reg  <= key;
            mval_reg <= mark_value;
        end
    end

    assign table_full = cell_valid[TABLE_DEPTH-1];

    // Decode the command into cell control and the result
    always_comb
    begin
        ctl         = '0;
        ctl.capture = (phase_reg == PH_CMP);
        ctl.mval    = mval_reg;
        count_next  = count_reg;
        found_next  = enc_hit;
        mark_next   = 1'b0;
        full_next   = 1'b0;
        case (cmd_reg)
            CMD_OPEN:
            begin
                if (enc_hit)
                begin
                    mark_next = enc_mark;
                end
                else if (table_full)
                begin
                    full_next = 1'b1;
                end
                else
                begin
                    ctl.do_ins = upd_go;
                    count_next = count_reg + PW'(1);
                end
            end
            CMD_DELETE:
            begin
                if (enc_hit)
                begin
                    ctl.do_del = upd_go;
                    count_next = count_reg - PW'(1);
                end
            end
            CMD_SET_MARK:
            begin
                if (enc_hit)
                begin
                    ctl.do_set = upd_go;
                    mark_next  = mval_reg;
                end
            end
            CMD_CLEAR:
            begin
                ctl.do_clr = upd_go;
                count_next = '0;
            end
            default:
            begin
                mark_next = enc_mark;
            end
        endcase
    end

    // Update the entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (upd_go)
        begin
            count_reg <= count_next;
        end
    end

    // Cell row
    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        logic [KEY_BITS-1:0] p_key;
        logic                p_mark;
        logic                p_valid;
        logic                p_lt;
        logic [KEY_BITS-1:0] n_key;
        logic                n_mark;
        logic                n_valid;

        if (g == 0)
        begin : g_first
            assign p_key   = key_reg;
            assign p_mark  = 1'b0;
            assign p_valid = 1'b0;
            assign p_lt    = 1'b1;
        end
        else
        begin : g_mid
            assign p_key   = cell_key[g-1];
            assign p_mark  = cell_mark[g-1];
            assign p_valid = cell_valid[g-1];
            assign p_lt    = lt_vec[g-1];
        end

        if (g == TABLE_DEPTH - 1)
        begin : g_last
            assign n_key   = cell_key[g];
            assign n_mark  = 1'b0;
            assign n_valid = 1'b0;
        end
        else
        begin : g_inner
            assign n_key   = cell_key[g+1];
            assign n_mark  = cell_mark[g+1];
            assign n_valid = cell_valid[g+1];
        end

        skt_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .key_in     (key_reg),
            .prev_key   (p_key),
            .prev_mark  (p_mark),
            .prev_valid (p_valid),
            .prev_lt    (p_lt),
            .next_key   (n_key),
            .next_mark  (n_mark),
            .next_valid (n_valid),
            .cell_key   (cell_key[g]),
            .cell_mark  (cell_mark[g]),
            .cell_valid (cell_valid[g]),
            .lt_flag    (lt_vec[g]),
            .eq_flag    (eq_vec[g])
        );
    end

    // Encode position, found and mark from the registered flags
    skt_encode #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_encode (
        .lt_vec   (lt_vec),
        .eq_vec   (eq_vec),
        .mark_vec (cell_mark),
        .pos      (enc_pos),
        .hit      (enc_hit),
        .hit_mark (enc_mark)
    );

    // Hold the result word until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (upd_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_go)
        begin
            found_reg <= found_next;
            pos_reg   <= enc_pos;
            mark_reg  <= mark_next;
            full_reg  <= full_next;
        end
    end

    // Fit position and count to the 9-bit result fields
    assign pos_wide   = {{OUT_POS_BITS{1'b0}}, pos_reg};
    assign count_wide = {{OUT_POS_BITS{1'b0}}, count_reg};

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign position    = pos_wide[OUT_POS_BITS-1:0];
    assign mark        = mark_reg;
    assign full_error  = full_reg;
    assign entry_count = count_wide[OUT_POS_BITS-1:0];

endmodule

>>> rtl/skt_checker.sv
// ----------------------------------------------------------------------------
// skt_checker: port-level checks for the sorted key table
// Watches both channels and checks how the result fields relate.
// ----------------------------------------------------------------------------
module skt_checker
    import skt_pkg::*;
#(
    parameter int KEY_BITS = 32
)
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic [2:0]                 cmd,
    input logic signed [KEY_BITS-1:0] key,
    input logic                       mark_value,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic                       found,
    input logic [OUT_POS_BITS-1:0]    position,
    input logic                       mark,
    input logic                       full_error,
    input logic [OUT_POS_BITS-1:0]    entry_count
);

    // Stalled input word holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(cmd) && $stable(key)
            && $stable(mark_value))
        else $error("stalled input word changed");

    // Stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(position)
            && $stable(entry_count) && $stable(found) && $stable(mark))
        else $error("stalled result word changed");

    // A set mark implies the key is present
    a_mark_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mark |-> found)
        else $error("mark set for an absent key");

    // A full table rejects only keys that are absent
    a_full_absent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && full_error |-> !found && !mark)
        else $error("full error on a present key");

    // A full table is never empty
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && full_error |-> entry_count != '0)
        else $error("full error with an empty table");

endmodule

bind sorted_key_table_with_marks skt_checker #(
    .KEY_BITS (KEY_BITS)
) u_skt_checker (.*);

>>> test/sorted_key_table_with_marks_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_key_table_with_marks_tb: self-checking bench for the sorted key table
// Drives open, delete, set mark, query, clear and spare commands through the
// valid/stall input channel and predicts every result word with a local copy
// of the sorted table. Each result word is compared with the oldest pending
// prediction. The run covers directed corner cases, a full table, random
// traffic with bursty idling on both sides, and a back-to-back tail.
// ----------------------------------------------------------------------------
module sorted_key_table_with_marks_tb
    import skt_pkg::*;
();

    localparam int TABLE_DEPTH  = 256;
    localparam int KEY_BITS     = 32;
    localparam int CYCLE_LIMIT  = 250000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;

    // Spare command codes behave as query
    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    localparam logic signed [KEY_BITS-1:0] KEY_MIN = {1'b1, {(KEY_BITS-1){1'b0}}};
    localparam logic signed [KEY_BITS-1:0] KEY_MAX = {1'b0, {(KEY_BITS-1){1'b1}}};

    typedef struct packed {
        logic                    found;
        logic [OUT_POS_BITS-1:0] position;
        logic                    mark;
        logic                    full_error;
        logic [OUT_POS_BITS-1:0] entry_count;
    } table_result_t;

    logic                        clk;
    logic                        rst_n      = 1'b0;
    logic                        in_valid   = 1'b0;
    logic                        in_stall;
    logic [2:0]                  cmd        = CMD_QUERY;
    logic signed [KEY_BITS-1:0]  key        = '0;
    logic                        mark_value = 1'b0;
    logic                        out_valid;
    logic                        out_stall  = 1'b0;
    logic                        found;
    logic [OUT_POS_BITS-1:0]     position;
    logic                        mark;
    logic                        full_error;
    logic [OUT_POS_BITS-1:0]     entry_count;

    // Shadow copy of the table
    logic signed [KEY_BITS-1:0]  tbl_key [TABLE_DEPTH];
    logic                        tbl_mark [TABLE_DEPTH];
    int                          tbl_count = 0;

    table_result_t               pending_results [$];
    int                          mismatch_count = 0;
    bit                          sender_gaps    = 1'b0;
    bit                          sink_stalls    = 1'b0;
    int                          stall_left     = 0;

    sorted_key_table_with_marks #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .key         (key),
        .mark_value  (mark_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .found       (found),
        .position    (position),
        .mark        (mark),
        .full_error  (full_error),
        .entry_count (entry_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Apply one command to the shadow table and return the result it yields
    function automatic table_result_t table_apply(logic [2:0] op,
                                                  logic signed [KEY_BITS-1:0] k,
                                                  logic mv);
        table_result_t r;
        int            p;
        bit            hit;
        r = '0;
        p = 0;
        while (p < tbl_count && tbl_key[p] < k)
            p++;
        hit = (p < tbl_count) && (tbl_key[p] == k);
        case (op)
            CMD_OPEN:
            begin
                if (hit)
                    r.mark = tbl_mark[p];
                else if (tbl_count >= TABLE_DEPTH)
                    r.full_error = 1'b1;
                else
                begin
                    for (int i = tbl_count; i > p; i--)
                    begin
                        tbl_key[i]  = tbl_key[i-1];
                        tbl_mark[i] = tbl_mark[i-1];
                    end
                    tbl_key[p]  = k;
                    tbl_mark[p] = 1'b0;
                    tbl_count++;
                end
            end
            CMD_DELETE:
            begin
                if (hit)
                begin
                    for (int i = p; i + 1 < tbl_count; i++)
                    begin
                        tbl_key[i]  = tbl_key[i+1];
                        tbl_mark[i] = tbl_mark[i+1];
                    end
                    tbl_count--;
                end
            end
            CMD_SET_MARK:
            begin
                if (hit)
                begin
                    tbl_mark[p] = mv;
                    r.mark      = mv;
                end
            end
            CMD_CLEAR:
            begin
                tbl_count = 0;
                for (int i = 0; i < TABLE_DEPTH; i++)
                    tbl_mark[i] = 1'b0;
            end
            default:
            begin
                if (hit)
                    r.mark = tbl_mark[p];
            end
        endcase
        r.found       = hit;
        r.position    = OUT_POS_BITS'(p);
        r.entry_count = OUT_POS_BITS'(tbl_count);
        return r;
    endfunction

    // Choose a key: mostly stored keys and their neighbors, some small and wide values
    function automatic logic signed [KEY_BITS-1:0] pick_key();
        int                         roll;
        logic signed [KEY_BITS-1:0] k;
        roll = $urandom_range(0, 99);
        if (roll < 45 && tbl_count > 0)
            k = tbl_key[$urandom_range(0, tbl_count - 1)];
        else if (roll < 55 && tbl_count > 0)
            k = tbl_key[$urandom_range(0, tbl_count - 1)] + ($urandom_range(0, 1) ? 1 : -1);
        else if (roll < 80)
            k = KEY_BITS'(int'($urandom_range(0, 63)) - 32);
        else if (roll < 95)
            k = $urandom;
        else
        begin
            case ($urandom_range(0, 3))
                0:       k = KEY_MIN;
                1:       k = KEY_MAX;
                2:       k = '0;
                default: k = '1;
            endcase
        end
        return k;
    endfunction

    // Present one word, hold it until taken, then record its prediction
    task automatic send_word(logic [2:0] op, logic signed [KEY_BITS-1:0] k, logic mv);
        int gap;
        if (sender_gaps && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 15);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= op;
        key        <= k;
        mark_value <= mv;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        pending_results.push_back(table_apply(op, k, mv));
    endtask

    task automatic send_random_word();
        int         roll;
        logic [2:0] op;
        roll = $urandom_range(0, 99);
        if (roll < 37)
            op = CMD_OPEN;
        else if (roll < 57)
            op = CMD_DELETE;
        else if (roll < 73)
            op = CMD_SET_MARK;
        else if (roll < 91)
            op = CMD_QUERY;
        else if (roll < 93)
            op = CMD_CLEAR;
        else
            op = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        send_word(op, pick_key(), 1'($urandom_range(0, 1)));
    endtask

    task automatic report_mismatch(string what, table_result_t exp_r, table_result_t act_r);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
        begin
            $display("%0t mismatch (%s): exp found=%0d pos=%0d mark=%0d full=%0d cnt=%0d",
                     $realtime, what, exp_r.found, exp_r.position, exp_r.mark,
                     exp_r.full_error, exp_r.entry_count);
            $display("    got found=%0d pos=%0d mark=%0d full=%0d cnt=%0d",
                     act_r.found, act_r.position, act_r.mark,
                     act_r.full_error, act_r.entry_count);
        end
    endtask

    // Check each taken result word against the oldest prediction
    always @(posedge clk)
    begin
        table_result_t act_r;
        table_result_t exp_r;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            act_r.found       = found;
            act_r.position    = position;
            act_r.mark        = mark;
            act_r.full_error  = full_error;
            act_r.entry_count = entry_count;
            if (pending_results.size() == 0)
                report_mismatch("unexpected word", '0, act_r);
            else
            begin
                exp_r = pending_results.pop_front();
                if (act_r !== exp_r)
                    report_mismatch("field", exp_r, act_r);
            end
        end
    end

    // Stall the result channel in random bursts
    always @(posedge clk)
    begin
        if (!sink_stalls)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 14);
        end
        else
            out_stall <= 1'b0;
    end

    // Abort a hung run
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Corner cases on a small table: extremes, every command, absent keys
    task automatic test_directed_cases();
        sender_gaps = 1'b1;
        sink_stalls = 1'b1;
        send_word(CMD_QUERY, '0, 1'b0);
        send_word(CMD_DELETE, KEY_MIN, 1'b0);
        send_word(CMD_OPEN, '0, 1'b1);
        send_word(CMD_OPEN, KEY_MIN, 1'b0);
        send_word(CMD_OPEN, KEY_MAX, 1'b0);
        send_word(CMD_OPEN, '1, 1'b0);
        send_word(CMD_OPEN, 1, 1'b0);
        send_word(CMD_OPEN, KEY_MAX, 1'b0);
        send_word(CMD_SET_MARK, KEY_MIN, 1'b1);
        send_word(CMD_QUERY, KEY_MIN, 1'b0);
        send_word(CMD_OPEN, KEY_MIN, 1'b0);
        send_word(CMD_SET_MARK, 5, 1'b1);
        send_word(CMD_QUERY, 2, 1'b1);
        send_word(CMD_DELETE, 7, 1'b0);
        send_word(CMD_SET_MARK, KEY_MAX, 1'b1);
        for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++)
            send_word(3'(c), KEY_MAX, 1'b0);
        send_word(CMD_DELETE, '0, 1'b1);
        send_word(CMD_QUERY, 1, 1'b0);
        send_word(CMD_SET_MARK, KEY_MIN, 1'b0);
        send_word(CMD_CLEAR, 1, 1'b0);
        send_word(CMD_QUERY, KEY_MAX, 1'b0);
        send_word(CMD_OPEN, KEY_MAX, 1'b1);
    endtask

    // Fill the table, then hit it with opens that need room and edits at both ends
    task automatic test_full_table();
        sender_gaps = 1'b1;
        sink_stalls = 1'b1;
        send_word(CMD_CLEAR, '0, 1'b0);
        while (tbl_count < TABLE_DEPTH)
        begin
            send_word(CMD_OPEN, $urandom, 1'b0);
            if ($urandom_range(0, 7) == 0)
                send_word(CMD_SET_MARK, tbl_key[$urandom_range(0, tbl_count - 1)], 1'b1);
        end
        send_word(CMD_OPEN, KEY_MIN, 1'b0);
        send_word(CMD_OPEN, KEY_MAX, 1'b1);
        send_word(CMD_OPEN, $urandom, 1'b0);
        send_word(CMD_OPEN, tbl_key[0], 1'b0);
        send_word(CMD_OPEN, tbl_key[TABLE_DEPTH-1], 1'b0);
        send_word(CMD_QUERY, tbl_key[TABLE_DEPTH/2], 1'b0);
        send_word(CMD_DELETE, tbl_key[TABLE_DEPTH/3], 1'b0);
        send_word(CMD_OPEN, KEY_MAX, 1'b0);
        send_word(CMD_OPEN, $urandom, 1'b0);
        send_word(CMD_SET_MARK, tbl_key[TABLE_DEPTH-1], 1'b1);
        send_word(CMD_QUERY, tbl_key[TABLE_DEPTH-1], 1'b0);
        send_word(CMD_DELETE, tbl_key[TABLE_DEPTH-1], 1'b0);
        send_word(CMD_DELETE, tbl_key[0], 1'b0);
        // Churn near the top of the table
        repeat (30)
            send_random_word();
        send_word(CMD_CLEAR, tbl_key[0], 1'b0);
    endtask

    // Random traffic, idling switched on and off in stretches
    task automatic test_random_traffic();
        for (int n = 0; n < 320; n++)
        begin
            if (n % 40 == 0)
            begin
                sender_gaps = $urandom_range(0, 2) != 0;
                sink_stalls = $urandom_range(0, 2) != 0;
            end
            send_random_word();
        end
    endtask

    // Closing stretch with neither side idling
    task automatic test_back_to_back();
        sender_gaps = 1'b0;
        sink_stalls = 1'b0;
        repeat (100)
            send_random_word();
    endtask

    initial
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            tbl_key[i]  = '0;
            tbl_mark[i] = 1'b0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_full_table();
        test_random_traffic();
        test_back_to_back();
        in_valid <= 1'b0;
        // Drain, then keep watching for stray words
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
